// ----- hw/rtl/msr_pkg.sv -----
package msr_pkg;

  // Field widths of the channel payloads and the configuration register.
  localparam int unsigned ChW    = 3;
  localparam int unsigned WidthW = 12;
  localparam int unsigned ReqW   = 16;
  localparam int unsigned StepW  = 16;

  // Default channel count and the step size after reset.
  localparam int unsigned NumChannelsDef = 5;
  localparam logic [StepW-1:0] StepReset = 16'd20;

  // Item modes.
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SET  = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_EMIT
  } seq_state_e;

  // Control handed from the sequencer to the datapath.
  typedef struct packed {
    logic ready;
    logic step_en;
    logic step_first;
    logic emit_en;
    logic seq_last;
  } seq_ctrl_t;

  // Lower pulse-width limit of each channel.
  function automatic logic [WidthW-1:0] limit_lo(input logic [ChW-1:0] ch);
    logic [WidthW-1:0] v;
    unique case (ch)
      3'd0:    v = 12'd700;
      3'd1:    v = 12'd500;
      3'd2:    v = 12'd500;
      3'd3:    v = 12'd700;
      3'd4:    v = 12'd600;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

  // Upper pulse-width limit of each channel.
  function automatic logic [WidthW-1:0] limit_hi(input logic [ChW-1:0] ch);
    logic [WidthW-1:0] v;
    unique case (ch)
      3'd0:    v = 12'd2300;
      3'd1:    v = 12'd1700;
      3'd2:    v = 12'd2400;
      3'd3:    v = 12'd2300;
      3'd4:    v = 12'd2400;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

  // Pulse width of each channel after reset.
  function automatic logic [WidthW-1:0] reset_width(input logic [ChW-1:0] ch);
    logic [WidthW-1:0] v;
    unique case (ch)
      3'd0:    v = 12'd1500;
      3'd1:    v = 12'd1500;
      3'd2:    v = 12'd2000;
      3'd3:    v = 12'd1500;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/msr_in_if.sv -----
interface msr_in_if import msr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ChW-1:0]    channel;
  logic [ReqW-1:0]   target;

  modport source (output valid, output mode, output channel, output target, input ready);
  modport sink   (input valid, input mode, input channel, input target, output ready);
endinterface

// ----- hw/rtl/msr_out_if.sv -----
interface msr_out_if import msr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ChW-1:0]    out_channel;
  logic [WidthW-1:0] position;
  logic              all_reached;
  logic              last;

  modport source (output valid, output out_channel, output position, output all_reached,
                  output last, input ready);
  modport sink   (input valid, input out_channel, input position, input all_reached,
                  input last, output ready);
endinterface

// ----- hw/rtl/msr_slew.sv -----
module msr_slew import msr_pkg::*; (
  input  logic [WidthW-1:0] cur_i,
  input  logic [WidthW-1:0] tgt_i,
  input  logic [StepW-1:0]  step_i,
  output logic [WidthW-1:0] next_o
);

  logic              up;
  logic [WidthW-1:0] gap;
  logic [StepW-1:0]  cur_ext;

  // Compares for direction, arrival and overshoot, two subtracts for the distance, one add or subtract for the move.
  always_comb begin
    up      = cur_i < tgt_i;
    gap     = up ? (tgt_i - cur_i) : (cur_i - tgt_i);
    cur_ext = {{(StepW-WidthW){1'b0}}, cur_i};
    if (cur_i == tgt_i) begin
      next_o = cur_i;
    end else if ({{(StepW-WidthW){1'b0}}, gap} < step_i) begin
      next_o = tgt_i;
    end else if (up) begin
      next_o = WidthW'(cur_ext + step_i);
    end else begin
      next_o = WidthW'(cur_ext - step_i);
    end
  end

endmodule

// ----- hw/rtl/msr_seq.sv -----
module msr_seq import msr_pkg::*; #(
  parameter int unsigned NumChannels = NumChannelsDef,
  localparam int unsigned IdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tick_start_i,
  input  logic            skip_step_i,
  input  logic            emit_free_i,
  output seq_ctrl_t       ctrl_o,
  output logic [IdxW-1:0] idx_o
);

  localparam logic [IdxW-1:0] IdxLast = IdxW'(NumChannels - 1);

  seq_state_e      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            at_last;

  assign at_last = idx_q == IdxLast;
  assign idx_o   = idx_q;

  // Next state: a tick walks the step pass, then the report pass; the step pass is skipped while skip_step_i is set.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (tick_start_i) begin
          state_d = skip_step_i ? ST_EMIT : ST_STEP;
        end
      end
      ST_STEP: begin
        if (at_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_free_i && at_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs toward the datapath.
  always_comb begin
    ctrl_o.ready      = state_q == ST_IDLE;
    ctrl_o.step_en    = state_q == ST_STEP;
    ctrl_o.step_first = idx_q == '0;
    ctrl_o.emit_en    = (state_q == ST_EMIT) && emit_free_i;
    ctrl_o.seq_last   = at_last;
  end

  // Channel index, restarted per tick and per pass.
  always_comb begin
    idx_d = idx_q;
    if (tick_start_i) begin
      idx_d = '0;
    end else if (ctrl_o.step_en || ctrl_o.emit_en) begin
      idx_d = at_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ----- hw/rtl/multi_servo_slew_ramp_unit.sv -----
// Servo slew-rate limiter for up to five channels.
// Input channel in_i carries one beat per item: mode selects a tick or a
// set-target. A set-target clamps target to the channel's fixed limits,
// stores it and clears the reached flag; it gives no
// output beat, and an out-of-range channel is dropped.
// A tick gives NumChannels output beats on out_o, channel 0 first, each with
// the position after the tick, the reached flag after the tick and last set
// on the final channel.
// A tick walks the channels through one shared slew unit, one channel per
// cycle, then walks them again to load the output register, one beat per
// cycle while the sink takes every beat; in_i is not ready through both walks.
// While reached is set the walk through the slew unit is skipped.
// When the sink stalls the output register holds its beat and the report
// pass waits; after the last beat is loaded in_i is ready again.
// Step size is written through cfg_we_i / cfg_wdata_i; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset sets the positions to their rest widths, the targets to zero, the
// reached flag and a step size of 20.
module multi_servo_slew_ramp_unit import msr_pkg::*; #(
  parameter int unsigned NumChannels = NumChannelsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [StepW-1:0] cfg_wdata_i,
  msr_in_if.sink           in_i,
  msr_out_if.source        out_o
);

  localparam int unsigned IdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  seq_ctrl_t         ctrl;
  logic [IdxW-1:0]   idx;
  logic [StepW-1:0]  step_q;
  logic [WidthW-1:0] cur_q [NumChannels];
  logic [WidthW-1:0] tgt_q [NumChannels];
  logic              reached_q;
  logic              all_eq_q;
  logic              all_eq_d;
  logic              in_fire;
  logic              tick_start;
  logic              set_ok;
  logic [WidthW-1:0] clamped;
  logic [WidthW-1:0] slew_next;
  logic              emit_free;
  logic              out_valid_q;
  logic [ChW-1:0]    out_ch_q;
  logic [WidthW-1:0] out_pos_q;
  logic              out_all_q;
  logic              out_last_q;

  assign in_fire    = in_i.valid && in_i.ready;
  assign tick_start = in_fire && (in_i.mode == MODE_TICK);
  assign set_ok     = in_fire && (in_i.mode == MODE_SET) && (in_i.channel < ChW'(NumChannels));
  assign emit_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = ctrl.ready;

  msr_seq #(.NumChannels(NumChannels)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_start_i(tick_start),
    .skip_step_i (reached_q),
    .emit_free_i (emit_free),
    .ctrl_o      (ctrl),
    .idx_o       (idx)
  );

  msr_slew u_slew (
    .cur_i (cur_q[idx]),
    .tgt_i (tgt_q[idx]),
    .step_i(step_q),
    .next_o(slew_next)
  );

  // Clamp the requested width to the channel's limits.
  always_comb begin
    if (in_i.target < {{(ReqW-WidthW){1'b0}}, limit_lo(in_i.channel)}) begin
      clamped = limit_lo(in_i.channel);
    end else if (in_i.target > {{(ReqW-WidthW){1'b0}}, limit_hi(in_i.channel)}) begin
      clamped = limit_hi(in_i.channel);
    end else begin
      clamped = in_i.target[WidthW-1:0];
    end
  end

  // Running check that every channel so far sits on its target.
  assign all_eq_d = (ctrl.step_first || all_eq_q) && (slew_next == tgt_q[idx]);

  // Step size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepReset;
    end else if (cfg_we_i) begin
      step_q <= cfg_wdata_i;
    end
  end

  // Channel state: positions move in the step pass, targets load on set-target.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        cur_q[i] <= reset_width(ChW'(i));
        tgt_q[i] <= '0;
      end
      reached_q <= 1'b1;
      all_eq_q  <= 1'b1;
    end else begin
      if (ctrl.step_en) begin
        cur_q[idx] <= slew_next;
        all_eq_q   <= all_eq_d;
        if (ctrl.seq_last) begin
          reached_q <= all_eq_d;
        end
      end
      if (set_ok) begin
        tgt_q[in_i.channel[IdxW-1:0]] <= clamped;
        reached_q                     <= 1'b0;
      end
    end
  end

  // Output register, loaded one channel per beat in the report pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit_en) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit_en) begin
      out_ch_q   <= ChW'(idx);
      out_pos_q  <= cur_q[idx];
      out_all_q  <= reached_q;
      out_last_q <= ctrl.seq_last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_channel = out_ch_q;
  assign out_o.position    = out_pos_q;
  assign out_o.all_reached = out_all_q;
  assign out_o.last        = out_last_q;

  // Positions only move while no new item can be taken.
  a_step_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.step_en |-> !in_i.ready)
    else $error("channel step while input is ready");

  // The closing beat of a tick reports the highest channel.
  a_last_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> (out_o.out_channel == ChW'(NumChannels - 1)))
    else $error("last beat on wrong channel");

  // The reached flag only sets at the end of a step pass.
  a_reached_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(reached_q) |-> $past(ctrl.step_en && ctrl.seq_last))
    else $error("reached set outside the end of a step pass");

  // A valid set-target always clears the reached flag.
  a_set_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_ok |=> !reached_q)
    else $error("set-target left reached set");

  // A beat is never loaded over one that the sink has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit_en |-> (!out_o.valid || out_o.ready))
    else $error("output beat overwritten");

endmodule
